FILE: src/modem_uart_register_block_top_macros.svh
// assertion macros for the modem uart register block
`ifndef MODEM_UART_REGISTER_BLOCK_TOP_MACROS_SVH
`define MODEM_UART_REGISTER_BLOCK_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off during reset
`define MUB_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MUB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define MUB_ASSERT_SAME(lbl, ante, cons)
`define MUB_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: src/mub_pkg.sv
// types and constants shared by the modem uart register block
package mub_pkg;

    // opcodes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // register addresses
    localparam logic [1:0] REG_DATA   = 2'd0;
    localparam logic [1:0] REG_STATUS = 2'd1;
    localparam logic [1:0] REG_MODEM  = 2'd2;
    localparam logic [1:0] REG_TIMER  = 2'd3;

    // modem control bit positions
    localparam int MC_BRS  = 0;
    localparam int MC_TXE  = 1;
    localparam int MC_ORIG = 2;
    localparam int MC_OH   = 7;
    localparam logic [7:0] MC_LINE_MASK = 8'h1F;

    // line control bit positions
    localparam int LC_PAR_LO = 0;
    localparam int LC_LEN_LO = 1;
    localparam int LC_LEN_HI = 2;
    localparam int LC_STOP   = 3;
    localparam int LC_PAR_HI = 4;

    // parity mode codes
    localparam logic [1:0] PAR_ODD  = 2'd0;
    localparam logic [1:0] PAR_EVEN = 2'd1;
    localparam logic [1:0] PAR_NONE = 2'd2;

    // reset values
    localparam logic [7:0]  LINE_CTL_RESET    = 8'h16;
    localparam logic [15:0] TIMER_TICKS_RESET = 16'd50;

    typedef struct packed {
        logic [1:0] opcode;
        logic [1:0] reg_addr;
        logic [7:0] write_data;
        logic       rx_valid;
        logic [7:0] rx_byte;
        logic       ring_active;
        logic       carrier_active;
        logic       tx_idle;
    } mub_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_taken;
        logic       dtr_out;
        logic [3:0] data_bits;
        logic [1:0] parity_mode;
        logic [1:0] stop_bits;
        logic       baud_is_300;
        logic       line_cfg_changed;
    } mub_result_t;

    typedef struct packed {
        logic rx_full;
        logic tx_empty;
        logic tx_pending;
    } mub_stat_t;

endpackage

FILE: src/mub_req_if.sv
// request channel: bus accesses and service ticks
interface mub_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [1:0] reg_addr;
    logic [7:0] write_data;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       ring_active;
    logic       carrier_active;
    logic       tx_idle;

    modport source (
        output valid, opcode, reg_addr, write_data, rx_valid, rx_byte,
               ring_active, carrier_active, tx_idle,
        input  ready
    );

    modport sink (
        input  valid, opcode, reg_addr, write_data, rx_valid, rx_byte,
               ring_active, carrier_active, tx_idle,
        output ready
    );
endinterface

FILE: src/mub_rsp_if.sv
// response channel: one result per request
interface mub_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_taken;
    logic       dtr_out;
    logic [3:0] data_bits;
    logic [1:0] parity_mode;
    logic [1:0] stop_bits;
    logic       baud_is_300;
    logic       line_cfg_changed;

    modport source (
        output valid, read_data, tx_valid, tx_byte, rx_taken, dtr_out,
               data_bits, parity_mode, stop_bits, baud_is_300, line_cfg_changed,
        input  ready
    );

    modport sink (
        input  valid, read_data, tx_valid, tx_byte, rx_taken, dtr_out,
               data_bits, parity_mode, stop_bits, baud_is_300, line_cfg_changed,
        output ready
    );
endinterface

FILE: src/mub_in_stage.sv
// input register stage for request transactions
module mub_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               up_valid,
    output logic               up_ready,
    input  mub_pkg::mub_item_t up_item,
    output logic               dn_valid,
    input  logic               dn_ready,
    output mub_pkg::mub_item_t dn_item
);

    logic               valid_reg;
    mub_pkg::mub_item_t item_reg;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
    end

endmodule

FILE: src/mub_core.sv
// register state and per-transaction update logic
module mub_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  mub_pkg::mub_item_t   item,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data,
    output mub_pkg::mub_result_t result,
    output mub_pkg::mub_stat_t   stat
);

    logic [15:0] timer_ticks_reg;
    logic [7:0]  rx_data_reg,   rx_data_next;
    logic [7:0]  tx_data_reg,   tx_data_next;
    logic [7:0]  line_ctl_reg,  line_ctl_next;
    logic [7:0]  modem_ctl_reg, modem_ctl_next;
    logic        rrf_reg,  rrf_next;
    logic        tre_reg,  tre_next;
    logic        tmr_reg,  tmr_next;
    logic        cd_reg,   cd_next;
    logic        ri_n_reg, ri_n_next;
    logic        pending_reg, pending_next;
    logic        dtr_reg,  dtr_next;
    logic        baud_reg, baud_next;
    logic        armed_reg, armed_next;
    logic [15:0] count_reg, count_next;

    logic [7:0]  status_byte;
    logic [7:0]  mc_diff;
    logic [15:0] count_dec;
    logic [7:0]  rd;
    logic        txv;
    logic [7:0]  txb;
    logic        taken;
    logic        changed;

    assign status_byte = {ri_n_reg, cd_reg, tmr_reg, 3'b000, tre_reg, rrf_reg};
    assign mc_diff     = modem_ctl_reg ^ item.write_data;
    assign count_dec   = (count_reg != 16'd0) ? (count_reg - 16'd1) : 16'd0;

    always_comb
    begin
        rx_data_next   = rx_data_reg;
        tx_data_next   = tx_data_reg;
        line_ctl_next  = line_ctl_reg;
        modem_ctl_next = modem_ctl_reg;
        rrf_next       = rrf_reg;
        tre_next       = tre_reg;
        tmr_next       = tmr_reg;
        cd_next        = cd_reg;
        ri_n_next      = ri_n_reg;
        pending_next   = pending_reg;
        dtr_next       = dtr_reg;
        baud_next      = baud_reg;
        armed_next     = armed_reg;
        count_next     = count_reg;
        rd             = 8'h00;
        txv            = 1'b0;
        txb            = 8'h00;
        taken          = 1'b0;
        changed        = 1'b0;

        case (item.opcode)
            mub_pkg::OP_READ:
            begin
                case (item.reg_addr)
                    mub_pkg::REG_DATA:
                    begin
                        rd       = rx_data_reg;
                        rrf_next = 1'b0;
                    end
                    mub_pkg::REG_STATUS:
                    begin
                        rd = status_byte;
                    end
                    default:
                    begin
                    end
                endcase
            end
            mub_pkg::OP_WRITE:
            begin
                case (item.reg_addr)
                    mub_pkg::REG_DATA:
                    begin
                        tx_data_next = item.write_data;
                        tre_next     = 1'b0;
                        pending_next = 1'b1;
                    end
                    mub_pkg::REG_STATUS:
                    begin
                        line_ctl_next = item.write_data;
                        changed       = 1'b1;
                    end
                    mub_pkg::REG_MODEM:
                    begin
                        modem_ctl_next = item.write_data;
                        // off hook dropped
                        if (mc_diff[mub_pkg::MC_OH] && !item.write_data[mub_pkg::MC_OH])
                        begin
                            dtr_next = 1'b0;
                        end
                        // off hook and originate both set after a change
                        if ((mc_diff[mub_pkg::MC_OH] || mc_diff[mub_pkg::MC_ORIG]) &&
                            item.write_data[mub_pkg::MC_OH] &&
                            item.write_data[mub_pkg::MC_ORIG])
                        begin
                            dtr_next = 1'b1;
                        end
                        if ((mc_diff & mub_pkg::MC_LINE_MASK) != 8'h00)
                        begin
                            baud_next = item.write_data[mub_pkg::MC_BRS];
                            changed   = 1'b1;
                        end
                    end
                    default:
                    begin
                        count_next = timer_ticks_reg;
                        armed_next = 1'b1;
                        tmr_next   = 1'b0;
                    end
                endcase
            end
            mub_pkg::OP_TICK:
            begin
                ri_n_next = !item.ring_active;
                cd_next   = item.carrier_active;
                // ring begins
                if (ri_n_reg && item.ring_active)
                begin
                    dtr_next = 1'b1;
                end
                // carrier lost
                if (cd_reg && !item.carrier_active)
                begin
                    dtr_next = 1'b0;
                end
                if (pending_reg && modem_ctl_reg[mub_pkg::MC_TXE])
                begin
                    txv          = 1'b1;
                    txb          = tx_data_reg;
                    pending_next = 1'b0;
                end
                if (!pending_next && item.tx_idle)
                begin
                    tre_next = 1'b1;
                end
                if (!rrf_reg && item.rx_valid)
                begin
                    rx_data_next = item.rx_byte;
                    rrf_next     = 1'b1;
                    taken        = 1'b1;
                end
                if (armed_reg)
                begin
                    count_next = count_dec;
                    if (count_dec == 16'd0)
                    begin
                        tmr_next = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.read_data        = rd;
        result.tx_valid         = txv;
        result.tx_byte          = txb;
        result.rx_taken         = taken;
        result.dtr_out          = dtr_next;
        result.data_bits        = 4'd5 +
            {2'b00, line_ctl_next[mub_pkg::LC_LEN_HI:mub_pkg::LC_LEN_LO]};
        case ({line_ctl_next[mub_pkg::LC_PAR_HI], line_ctl_next[mub_pkg::LC_PAR_LO]})
            2'b00:   result.parity_mode = mub_pkg::PAR_ODD;
            2'b01:   result.parity_mode = mub_pkg::PAR_EVEN;
            default: result.parity_mode = mub_pkg::PAR_NONE;
        endcase
        result.stop_bits        = line_ctl_next[mub_pkg::LC_STOP] ? 2'd2 : 2'd1;
        result.baud_is_300      = baud_next;
        result.line_cfg_changed = changed;
    end

    assign stat.rx_full    = rrf_reg;
    assign stat.tx_empty   = tre_reg;
    assign stat.tx_pending = pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_ticks_reg <= mub_pkg::TIMER_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            timer_ticks_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_data_reg   <= 8'h00;
            tx_data_reg   <= 8'h00;
            line_ctl_reg  <= mub_pkg::LINE_CTL_RESET;
            modem_ctl_reg <= 8'h00;
            rrf_reg       <= 1'b0;
            tre_reg       <= 1'b0;
            tmr_reg       <= 1'b0;
            cd_reg        <= 1'b0;
            ri_n_reg      <= 1'b1;
            pending_reg   <= 1'b0;
            dtr_reg       <= 1'b0;
            baud_reg      <= 1'b1;
            armed_reg     <= 1'b0;
            count_reg     <= 16'd0;
        end
        else if (go)
        begin
            rx_data_reg   <= rx_data_next;
            tx_data_reg   <= tx_data_next;
            line_ctl_reg  <= line_ctl_next;
            modem_ctl_reg <= modem_ctl_next;
            rrf_reg       <= rrf_next;
            tre_reg       <= tre_next;
            tmr_reg       <= tmr_next;
            cd_reg        <= cd_next;
            ri_n_reg      <= ri_n_next;
            pending_reg   <= pending_next;
            dtr_reg       <= dtr_next;
            baud_reg      <= baud_next;
            armed_reg     <= armed_next;
            count_reg     <= count_next;
        end
    end

endmodule

FILE: src/mub_out_stage.sv
// result register stage for response transactions
module mub_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  mub_pkg::mub_result_t up_result,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output mub_pkg::mub_result_t dn_result
);

    logic                 valid_reg;
    mub_pkg::mub_result_t result_reg;

    assign up_ready  = !valid_reg || dn_ready;
    assign dn_valid  = valid_reg;
    assign dn_result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            result_reg <= up_result;
        end
    end

endmodule

FILE: src/modem_uart_register_block_top.sv
// top level of the modem uart register block
//
// req carries one transaction per bus read, bus write or service tick;
// rsp returns exactly one result transaction for each, in order.
// cfg_wr_en / cfg_wr_data load the 16-bit timer tick count; write it only
// while no transaction is in flight.
// a request accepted at a clock edge sits in the input register, is
// processed by the register update logic and lands in the result register,
// which raises rsp.valid and holds it until the receiver takes the result.
// throughput is one transaction per cycle while rsp.ready stays high; the
// update of the register set from the input register is the whole per-item
// path.
// reset (rst_n low, asynchronous) empties both stages and restores the
// register set: status not-ringing set, line control 0x16, 300 baud,
// timer idle, tick count 50.
// when rsp.ready stays low the result register holds its transaction, the
// input register can still take one more, and then req.ready drops until
// the receiver takes the waiting result
`include "modem_uart_register_block_top_macros.svh"

module modem_uart_register_block_top (
    input  logic        clk,
    input  logic        rst_n,
    mub_req_if.sink     req,
    mub_rsp_if.source   rsp,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    mub_pkg::mub_item_t   req_item;
    mub_pkg::mub_item_t   s1_item;
    mub_pkg::mub_result_t core_result;
    mub_pkg::mub_result_t rsp_result;
    mub_pkg::mub_stat_t   core_stat;
    logic                 s1_valid;
    logic                 s2_ready;
    logic                 go;
    logic                 s1_is_tick;
    logic                 s1_is_data_write;

    // gather request fields
    assign req_item.opcode         = req.opcode;
    assign req_item.reg_addr       = req.reg_addr;
    assign req_item.write_data     = req.write_data;
    assign req_item.rx_valid       = req.rx_valid;
    assign req_item.rx_byte        = req.rx_byte;
    assign req_item.ring_active    = req.ring_active;
    assign req_item.carrier_active = req.carrier_active;
    assign req_item.tx_idle        = req.tx_idle;

    mub_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req.valid),
        .up_ready (req.ready),
        .up_item  (req_item),
        .dn_valid (s1_valid),
        .dn_ready (s2_ready),
        .dn_item  (s1_item)
    );

    // the register set advances exactly when a transaction moves to the result stage
    assign go = s1_valid && s2_ready;

    mub_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (go),
        .item        (s1_item),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .result      (core_result),
        .stat        (core_stat)
    );

    mub_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s1_valid),
        .up_ready  (s2_ready),
        .up_result (core_result),
        .dn_valid  (rsp.valid),
        .dn_ready  (rsp.ready),
        .dn_result (rsp_result)
    );

    // spread result fields
    assign rsp.read_data        = rsp_result.read_data;
    assign rsp.tx_valid         = rsp_result.tx_valid;
    assign rsp.tx_byte          = rsp_result.tx_byte;
    assign rsp.rx_taken         = rsp_result.rx_taken;
    assign rsp.dtr_out          = rsp_result.dtr_out;
    assign rsp.data_bits        = rsp_result.data_bits;
    assign rsp.parity_mode      = rsp_result.parity_mode;
    assign rsp.stop_bits        = rsp_result.stop_bits;
    assign rsp.baud_is_300      = rsp_result.baud_is_300;
    assign rsp.line_cfg_changed = rsp_result.line_cfg_changed;

    // decode of the transaction in the input register
    assign s1_is_tick       = (s1_item.opcode == mub_pkg::OP_TICK);
    assign s1_is_data_write = (s1_item.opcode == mub_pkg::OP_WRITE) &&
                              (s1_item.reg_addr == mub_pkg::REG_DATA);

    // a byte only goes out on a service tick
    `MUB_ASSERT_SAME(a_tx_only_on_tick, go && core_result.tx_valid, s1_is_tick)
    // a received byte is only latched while the receive holding register is empty
    `MUB_ASSERT_SAME(a_rx_only_when_empty, go && core_result.rx_taken, !core_stat.rx_full)
    // a data write always leaves a byte pending and transmit empty clear
    `MUB_ASSERT_NEXT(a_tx_write_pends, go && s1_is_data_write, core_stat.tx_pending && !core_stat.tx_empty)
    // request backpressure only while the result register is stalled
    `MUB_ASSERT_SAME(a_backpressure, !req.ready, rsp.valid && !rsp.ready && s1_valid)

endmodule

FILE: tb/sv/modem_uart_register_block_top_tb.sv
// testbench for the modem uart register block: bus, line and timer behavior against a predictor
`timescale 1ns / 100ps

module modem_uart_register_block_top_tb;

    // opcode with no function in the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // status byte bit positions
    localparam int ST_RX_FULL  = 0;
    localparam int ST_TX_EMPTY = 1;
    localparam int ST_TIMER    = 5;
    localparam int ST_CARRIER  = 6;
    localparam int ST_NO_RING  = 7;
    localparam logic [7:0] ST_ERR_MASK = 8'h1C;
    localparam logic [7:0] ST_RESET    = 8'h80;

    // margin waited after the last owed result has come back
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_ITEMS  = 305;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    mub_req_if req_ch();
    mub_rsp_if rsp_ch();

    modem_uart_register_block_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    // shadow copy of the register set, advanced once per accepted transaction
    logic [15:0] shadow_timer_ticks;
    logic [7:0]  shadow_rx_data;
    logic [7:0]  shadow_status;
    logic [7:0]  shadow_tx_data;
    logic [7:0]  shadow_line_ctl;
    logic [7:0]  shadow_modem_ctl;
    logic        shadow_tx_pending;
    logic        shadow_dtr;
    logic        shadow_baud_300;
    logic        shadow_timer_armed;
    logic [15:0] shadow_timer_count;

    // results still owed by the block, oldest first
    mub_pkg::mub_result_t due_responses[$];

    int unsigned cycle_count = 0;
    int          mismatches;
    int          items_sent;
    int          stall_left = 0;
    bit          idle_en;

    always #2 clk = ~clk;

    function automatic void reset_shadow();
        shadow_timer_ticks = mub_pkg::TIMER_TICKS_RESET;
        shadow_rx_data     = 8'h00;
        shadow_status      = ST_RESET;
        shadow_tx_data     = 8'h00;
        shadow_line_ctl    = mub_pkg::LINE_CTL_RESET;
        shadow_modem_ctl   = 8'h00;
        shadow_tx_pending  = 1'b0;
        shadow_dtr         = 1'b0;
        shadow_baud_300    = 1'b1;
        shadow_timer_armed = 1'b0;
        shadow_timer_count = 16'd0;
    endfunction

    // one transaction through the register set; returns the result it must produce
    function automatic mub_pkg::mub_result_t predict_register_step(
        input mub_pkg::mub_item_t item);
        mub_pkg::mub_result_t res;
        logic [7:0]  old_status;
        logic [7:0]  prev_mc;
        logic [7:0]  diff;
        logic [1:0]  par;
        res = '0;
        case (item.opcode)
            mub_pkg::OP_READ:
            begin
                if (item.reg_addr == mub_pkg::REG_DATA)
                begin
                    res.read_data = shadow_rx_data;
                    shadow_status[ST_RX_FULL] = 1'b0;
                end
                else if (item.reg_addr == mub_pkg::REG_STATUS)
                begin
                    // status read clears the error bits
                    res.read_data = shadow_status;
                    shadow_status = shadow_status & ~ST_ERR_MASK;
                end
            end
            mub_pkg::OP_WRITE:
            begin
                case (item.reg_addr)
                    mub_pkg::REG_DATA:
                    begin
                        shadow_tx_data = item.write_data;
                        shadow_status[ST_TX_EMPTY] = 1'b0;
                        shadow_tx_pending = 1'b1;
                    end
                    mub_pkg::REG_STATUS:
                    begin
                        shadow_line_ctl = item.write_data;
                        res.line_cfg_changed = 1'b1;
                    end
                    mub_pkg::REG_MODEM:
                    begin
                        prev_mc = shadow_modem_ctl;
                        diff = prev_mc ^ item.write_data;
                        shadow_modem_ctl = item.write_data;
                        // hanging up drops dtr
                        if (diff[mub_pkg::MC_OH] && !item.write_data[mub_pkg::MC_OH])
                            shadow_dtr = 1'b0;
                        // off hook and originate both set, with one of them new
                        if ((diff[mub_pkg::MC_OH] || diff[mub_pkg::MC_ORIG])
                            && item.write_data[mub_pkg::MC_OH]
                            && item.write_data[mub_pkg::MC_ORIG])
                            shadow_dtr = 1'b1;
                        if ((prev_mc & mub_pkg::MC_LINE_MASK) !=
                            (item.write_data & mub_pkg::MC_LINE_MASK))
                        begin
                            shadow_baud_300 = item.write_data[mub_pkg::MC_BRS];
                            res.line_cfg_changed = 1'b1;
                        end
                    end
                    default:
                    begin
                        // timer arm samples the tick count now
                        shadow_timer_count = shadow_timer_ticks;
                        shadow_timer_armed = 1'b1;
                        shadow_status[ST_TIMER] = 1'b0;
                    end
                endcase
            end
            mub_pkg::OP_TICK:
            begin
                old_status = shadow_status;
                shadow_status[ST_NO_RING] = !item.ring_active;
                if (old_status[ST_NO_RING] && item.ring_active)
                    shadow_dtr = 1'b1;
                shadow_status[ST_CARRIER] = item.carrier_active;
                if (old_status[ST_CARRIER] && !item.carrier_active)
                    shadow_dtr = 1'b0;
                if (shadow_tx_pending && shadow_modem_ctl[mub_pkg::MC_TXE])
                begin
                    res.tx_valid = 1'b1;
                    res.tx_byte = shadow_tx_data;
                    shadow_tx_pending = 1'b0;
                end
                if (!shadow_tx_pending && !shadow_status[ST_TX_EMPTY] && item.tx_idle)
                    shadow_status[ST_TX_EMPTY] = 1'b1;
                if (!shadow_status[ST_RX_FULL] && item.rx_valid)
                begin
                    shadow_rx_data = item.rx_byte;
                    shadow_status[ST_RX_FULL] = 1'b1;
                    shadow_status = shadow_status & ~ST_ERR_MASK;
                    res.rx_taken = 1'b1;
                end
                if (shadow_timer_armed)
                begin
                    if (shadow_timer_count != 16'd0)
                        shadow_timer_count = shadow_timer_count - 16'd1;
                    if (shadow_timer_count == 16'd0)
                        shadow_status[ST_TIMER] = 1'b1;
                end
            end
            default:
            begin
                // unused opcode: level outputs only
            end
        endcase

        // level outputs reflect the state after this transaction
        res.dtr_out = shadow_dtr;
        res.data_bits = 4'd5 +
            {2'b00, shadow_line_ctl[mub_pkg::LC_LEN_HI:mub_pkg::LC_LEN_LO]};
        par = {shadow_line_ctl[mub_pkg::LC_PAR_HI], shadow_line_ctl[mub_pkg::LC_PAR_LO]};
        if (par == 2'b00)
            res.parity_mode = mub_pkg::PAR_ODD;
        else if (par == 2'b01)
            res.parity_mode = mub_pkg::PAR_EVEN;
        else
            res.parity_mode = mub_pkg::PAR_NONE;
        res.stop_bits = shadow_line_ctl[mub_pkg::LC_STOP] ? 2'd2 : 2'd1;
        res.baud_is_300 = shadow_baud_300;
        return res;
    endfunction

    // every field random, then opcode and register forced
    function automatic mub_pkg::mub_item_t random_fields(input logic [1:0] op,
                                                         input logic [1:0] addr);
        mub_pkg::mub_item_t item;
        item.opcode         = op;
        item.reg_addr       = addr;
        item.write_data     = 8'($urandom_range(0, 255));
        item.rx_valid       = 1'($urandom_range(0, 1));
        item.rx_byte        = 8'($urandom_range(0, 255));
        item.ring_active    = 1'($urandom_range(0, 1));
        item.carrier_active = 1'($urandom_range(0, 1));
        item.tx_idle        = 1'($urandom_range(0, 1));
        return item;
    endfunction

    function automatic mub_pkg::mub_item_t bus_access(input logic [1:0] op,
                                                      input logic [1:0] addr,
                                                      input logic [7:0] data);
        mub_pkg::mub_item_t item;
        item = '0;
        item.opcode = op;
        item.reg_addr = addr;
        item.write_data = data;
        return item;
    endfunction

    function automatic mub_pkg::mub_item_t line_tick(input logic rxv, input logic [7:0] rxb,
                                                     input logic ring, input logic carrier,
                                                     input logic idle);
        mub_pkg::mub_item_t item;
        item = '0;
        item.opcode = mub_pkg::OP_TICK;
        item.rx_valid = rxv;
        item.rx_byte = rxb;
        item.ring_active = ring;
        item.carrier_active = carrier;
        item.tx_idle = idle;
        return item;
    endfunction

    // drive one request transaction; called and returns at a falling edge
    task automatic send_transaction(input mub_pkg::mub_item_t item);
        int gap;
        gap = 0;
        if (idle_en && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 16);
        if (gap != 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.opcode         = item.opcode;
        req_ch.reg_addr       = item.reg_addr;
        req_ch.write_data     = item.write_data;
        req_ch.rx_valid       = item.rx_valid;
        req_ch.rx_byte        = item.rx_byte;
        req_ch.ring_active    = item.ring_active;
        req_ch.carrier_active = item.carrier_active;
        req_ch.tx_idle        = item.tx_idle;
        req_ch.valid          = 1'b1;
        // valid stays up into the next transaction unless a gap lowers it
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        due_responses.push_back(predict_register_step(item));
        items_sent++;
        @(negedge clk);
    endtask

    // stop sending and let every owed result come back
    task automatic wait_for_quiet();
        req_ch.valid = 1'b0;
        while (due_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // timer tick count is only written with nothing in flight
    task automatic load_timer_ticks(input logic [15:0] ticks);
        wait_for_quiet();
        cfg_wr_data = ticks;
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        shadow_timer_ticks = ticks;
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch in %s at cycle %0d: expected %0h, got %0h",
                         name, cycle_count, want, got);
        end
    endtask

    // result side: random stall bursts; no new burst starts while idling is off
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            rsp_ch.ready = 1'b0;
            stall_left--;
        end
        else if (idle_en && $urandom_range(0, 5) == 0)
        begin
            rsp_ch.ready = 1'b0;
            stall_left = $urandom_range(0, 15);
        end
        else
            rsp_ch.ready = 1'b1;
    end

    // each result transaction against the oldest owed result
    always @(posedge clk)
    begin
        mub_pkg::mub_result_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (due_responses.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result transaction at cycle %0d with none owed", cycle_count);
            end
            else
            begin
                want = due_responses.pop_front();
                compare_field("read_data", want.read_data, rsp_ch.read_data);
                compare_field("tx_valid", 8'(want.tx_valid), 8'(rsp_ch.tx_valid));
                compare_field("tx_byte", want.tx_byte, rsp_ch.tx_byte);
                compare_field("rx_taken", 8'(want.rx_taken), 8'(rsp_ch.rx_taken));
                compare_field("dtr_out", 8'(want.dtr_out), 8'(rsp_ch.dtr_out));
                compare_field("data_bits", 8'(want.data_bits), 8'(rsp_ch.data_bits));
                compare_field("parity_mode", 8'(want.parity_mode), 8'(rsp_ch.parity_mode));
                compare_field("stop_bits", 8'(want.stop_bits), 8'(rsp_ch.stop_bits));
                compare_field("baud_is_300", 8'(want.baud_is_300), 8'(rsp_ch.baud_is_300));
                compare_field("line_cfg_changed", 8'(want.line_cfg_changed),
                              8'(rsp_ch.line_cfg_changed));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // reads of every register straight out of reset, and the unused opcode
    task automatic test_reset_state();
        mub_pkg::mub_item_t item;
        send_transaction(bus_access(mub_pkg::OP_READ, mub_pkg::REG_DATA, 8'h00));
        send_transaction(bus_access(mub_pkg::OP_READ, mub_pkg::REG_STATUS, 8'h00));
        send_transaction(bus_access(mub_pkg::OP_READ, mub_pkg::REG_MODEM, 8'hFF));
        send_transaction(bus_access(mub_pkg::OP_READ, mub_pkg::REG_TIMER, 8'hFF));
        // unused opcode with every other field at its top value
        item = '1;
        item.opcode = OP_UNUSED;
        send_transaction(item);
    endtask

    // line format decode extremes, and dtr / baud select from modem control
    task automatic test_line_and_modem_control();
        // 5 bits, odd, 1 stop
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_STATUS, 8'h00));
        // 8 bits, none, 2 stop
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_STATUS, 8'hFF));
        // even parity
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_STATUS, 8'h01));
        // off hook plus originate raises dtr, low bits change so 110 baud
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_MODEM, 8'h84));
        // on hook drops dtr, low bits unchanged so no reprogram pulse
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_MODEM, 8'h04));
        // off hook again with transmit enable and 300 baud
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_MODEM, 8'h87));
    endtask

    // byte out on a tick, byte in while receive is free, held off when full
    task automatic test_transmit_receive();
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_DATA, 8'hA5));
        send_transaction(line_tick(1'b1, 8'hFF, 1'b0, 1'b1, 1'b0));
        send_transaction(line_tick(1'b1, 8'h00, 1'b0, 1'b1, 1'b1));
        send_transaction(bus_access(mub_pkg::OP_READ, mub_pkg::REG_STATUS, 8'h00));
        send_transaction(bus_access(mub_pkg::OP_READ, mub_pkg::REG_DATA, 8'h00));
    endtask

    // ringing start raises dtr, carrier loss drops it
    task automatic test_ring_and_carrier();
        send_transaction(line_tick(1'b0, 8'h00, 1'b1, 1'b1, 1'b1));
        send_transaction(line_tick(1'b0, 8'h00, 1'b0, 1'b0, 1'b1));
    endtask

    // zero count fires on the first tick, count of one after one tick, top count
    task automatic test_timer();
        load_timer_ticks(16'd0);
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_TIMER, 8'hFF));
        send_transaction(line_tick(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        load_timer_ticks(16'd1);
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_TIMER, 8'h00));
        send_transaction(line_tick(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
        send_transaction(bus_access(mub_pkg::OP_READ, mub_pkg::REG_STATUS, 8'h00));
        load_timer_ticks(16'hFFFF);
        send_transaction(bus_access(mub_pkg::OP_WRITE, mub_pkg::REG_TIMER, 8'h00));
        send_transaction(line_tick(1'b0, 8'h00, 1'b0, 1'b0, 1'b0));
    endtask

    // a dial-up exchange: go off hook, queue a byte, maybe arm the timer, service the line, read back
    task automatic send_session();
        mub_pkg::mub_item_t item;
        int n;
        item = random_fields(mub_pkg::OP_WRITE, mub_pkg::REG_MODEM);
        item.write_data[mub_pkg::MC_OH] = 1'b1;
        item.write_data[mub_pkg::MC_TXE] = ($urandom_range(0, 3) != 0);
        send_transaction(item);
        send_transaction(random_fields(mub_pkg::OP_WRITE, mub_pkg::REG_DATA));
        if ($urandom_range(0, 2) == 0)
            send_transaction(random_fields(mub_pkg::OP_WRITE, mub_pkg::REG_TIMER));
        n = $urandom_range(1, 4);
        repeat (n)
            send_transaction(random_fields(mub_pkg::OP_TICK, 2'($urandom_range(0, 3))));
        send_transaction(random_fields(mub_pkg::OP_READ, mub_pkg::REG_STATUS));
        send_transaction(random_fields(mub_pkg::OP_READ, mub_pkg::REG_DATA));
    endtask

    // one timer setting, mostly exchanges with random noise in between
    task automatic run_traffic_phase(input logic [15:0] ticks, input bit allow_idle);
        int start;
        int sel;
        logic [1:0] op;
        load_timer_ticks(ticks);
        idle_en = allow_idle;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            // stretches with and without idling
            if ($urandom_range(0, 30) == 0)
                idle_en = allow_idle && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6)
                send_session();
            else
            begin
                sel = $urandom_range(0, 15);
                if (sel < 5)
                    op = mub_pkg::OP_READ;
                else if (sel < 10)
                    op = mub_pkg::OP_WRITE;
                else if (sel < 15)
                    op = mub_pkg::OP_TICK;
                else
                    op = OP_UNUSED;
                send_transaction(random_fields(op, 2'($urandom_range(0, 3))));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_traffic_phase(16'd5, 1'b1);
        run_traffic_phase(16'd1, 1'b1);
        run_traffic_phase(16'hFFFF, 1'b1);
        run_traffic_phase(16'($urandom_range(2, 30)), 1'b1);
        run_traffic_phase(16'd12, 1'b1);
        // final stretch at full rate on both sides
        run_traffic_phase(16'd3, 1'b0);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = 16'd0;
        req_ch.valid = 1'b0;
        req_ch.opcode = mub_pkg::OP_READ;
        req_ch.reg_addr = mub_pkg::REG_DATA;
        req_ch.write_data = 8'h00;
        req_ch.rx_valid = 1'b0;
        req_ch.rx_byte = 8'h00;
        req_ch.ring_active = 1'b0;
        req_ch.carrier_active = 1'b0;
        req_ch.tx_idle = 1'b0;
        mismatches = 0;
        items_sent = 0;
        idle_en = 1'b1;
        reset_shadow();

        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_line_and_modem_control();
        test_transmit_receive();
        test_ring_and_carrier();
        test_timer();
        test_random_traffic();

        idle_en = 1'b0;
        wait_for_quiet();
        // anything still owed never arrived
        mismatches += due_responses.size();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/mub_pkg.sv
src/mub_req_if.sv
src/mub_rsp_if.sv
src/mub_in_stage.sv
src/mub_core.sv
src/mub_out_stage.sv
src/modem_uart_register_block_top.sv
tb/sv/modem_uart_register_block_top_tb.sv
